@@ src/gcv_pkg.sv @@
// Shared types and fixed-point widths for the gradient centre vote map.
`default_nettype none
package gcv_pkg;
    localparam int POSW = 6;
    localparam int GW   = 16;
    localparam int VW   = 48;
    localparam int DW   = 10;
    localparam int TOPW = 27;
    localparam int T2W  = 52;
    localparam int D2W  = 17;
    localparam int QN   = 33;

    typedef struct packed {
        logic                 read;
        logic                 in_map;
        logic [POSW-1:0]      px;
        logic [POSW-1:0]      py;
        logic signed [GW-1:0] gx;
        logic signed [GW-1:0] gy;
    } item_t;
endpackage
`default_nettype wire

@@ src/gcv_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module gcv_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end
endmodule
`default_nettype wire

@@ src/gcv_front.sv @@
// Front end: accepts transactions, classifies them and queues the useful ones.
`default_nettype none
module gcv_front #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          valid,
    output logic                               ready,
    input  wire logic                          command,
    input  wire logic [gcv_pkg::POSW-1:0]      pos_x,
    input  wire logic [gcv_pkg::POSW-1:0]      pos_y,
    input  wire logic signed [gcv_pkg::GW-1:0] grad_x,
    input  wire logic signed [gcv_pkg::GW-1:0] grad_y,
    output logic                               q_valid,
    output gcv_pkg::item_t                     q_item,
    input  wire logic                          q_pop
);
    gcv_pkg::item_t mem_reg [2];
    logic           wr_ptr_reg, rd_ptr_reg;
    logic [1:0]     count_reg;
    gcv_pkg::item_t item;
    logic           keep, push;

    always_comb
    begin
        item.read   = command;
        item.in_map = (32'(pos_x) < MAP_WIDTH) && (32'(pos_y) < MAP_HEIGHT);
        item.px     = pos_x;
        item.py     = pos_y;
        item.gx     = grad_x;
        item.gy     = grad_y;
        keep = command || (item.in_map && ((grad_x != '0) || (grad_y != '0)));
    end

    assign ready   = (count_reg != 2'd2);
    assign push    = valid && ready && keep;
    assign q_valid = (count_reg != 2'd0);
    assign q_item  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (q_pop)
            begin
                rd_ptr_reg <= ~rd_ptr_reg;
            end
            count_reg <= count_reg + 2'(push) - 2'(q_pop);
        end
    end
endmodule
`default_nettype wire

@@ src/gcv_back.sv @@
// Back end: clears the map, walks candidates with a serial divider and serves reads.
`default_nettype none
module gcv_back #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     q_valid,
    input  wire gcv_pkg::item_t           q_item,
    output logic                          q_pop,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic [gcv_pkg::VW-1:0]        vote_value
);
    localparam int CELLS = MAP_WIDTH * MAP_HEIGHT;
    localparam int AW    = $clog2(CELLS);
    localparam int KW    = $clog2(MAP_WIDTH);
    localparam int JW    = $clog2(MAP_HEIGHT);
    localparam int CW    = $clog2(gcv_pkg::QN + 1);

    typedef enum logic [2:0] {S_CLEAR, S_IDLE, S_RD_WAIT, S_TOP, S_SQ, S_DIV, S_ACC} state_t;

    state_t                           state_reg;
    logic [AW-1:0]                    addr_reg;
    logic [KW-1:0]                    k_reg;
    logic [JW-1:0]                    j_reg;
    gcv_pkg::item_t                   cur_reg;
    logic signed [gcv_pkg::TOPW-1:0]  top_reg;
    logic [gcv_pkg::D2W-1:0]          d2_reg;
    logic                             self_reg;
    logic [gcv_pkg::D2W-1:0]          rem_reg;
    logic [gcv_pkg::QN-1:0]           dvd_reg;
    logic [gcv_pkg::QN-1:0]           q_reg;
    logic [CW-1:0]                    cnt_reg;
    logic                             out_valid_reg;
    logic [gcv_pkg::VW-1:0]           out_reg;

    logic                             wr_en, rd_en;
    logic [AW-1:0]                    wr_addr, rd_addr;
    logic [gcv_pkg::VW-1:0]           wr_data, rd_data;
    logic signed [gcv_pkg::DW-1:0]    dx, dy;
    logic signed [gcv_pkg::TOPW-1:0]  top_c;
    logic [gcv_pkg::D2W-1:0]          d2_c;
    logic [gcv_pkg::T2W-1:0]          t2_c;
    logic [gcv_pkg::D2W:0]            sh;
    logic                             ge;
    logic [gcv_pkg::VW:0]             sum;
    logic                             last;
    logic [AW-1:0]                    rd_idx;

    gcv_ram #(.WIDTH(gcv_pkg::VW), .DEPTH(CELLS)) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_comb
    begin
        dx    = gcv_pkg::DW'(cur_reg.px) - gcv_pkg::DW'(k_reg);
        dy    = gcv_pkg::DW'(cur_reg.py) - gcv_pkg::DW'(j_reg);
        top_c = gcv_pkg::TOPW'(cur_reg.gx * dx) + gcv_pkg::TOPW'(cur_reg.gy * dy);
        d2_c  = gcv_pkg::D2W'(dx * dx) + gcv_pkg::D2W'(dy * dy);
        t2_c  = gcv_pkg::T2W'(top_reg[gcv_pkg::TOPW-2:0]) *
                gcv_pkg::T2W'(top_reg[gcv_pkg::TOPW-2:0]);
        sh    = {rem_reg, dvd_reg[gcv_pkg::QN-1]};
        ge    = (sh >= {1'b0, d2_reg});
        sum   = {1'b0, rd_data} + (gcv_pkg::VW+1)'(q_reg);
        last  = (k_reg == KW'(MAP_WIDTH - 1)) && (j_reg == JW'(MAP_HEIGHT - 1));
        rd_idx = AW'(32'(q_item.py) * MAP_WIDTH + 32'(q_item.px));

        q_pop   = 1'b0;
        rd_en   = 1'b0;
        rd_addr = addr_reg;
        wr_en   = 1'b0;
        wr_addr = addr_reg;
        wr_data = '0;
        unique case (state_reg)
            S_CLEAR:
            begin
                wr_en = 1'b1;
            end
            S_IDLE:
            begin
                if (q_valid && (!q_item.read || !out_valid_reg))
                begin
                    q_pop = 1'b1;
                    if (q_item.read && q_item.in_map)
                    begin
                        rd_en   = 1'b1;
                        rd_addr = rd_idx;
                    end
                end
            end
            S_TOP:
            begin
                rd_en = 1'b1;
            end
            S_ACC:
            begin
                wr_en   = 1'b1;
                wr_data = sum[gcv_pkg::VW] ? '1 : sum[gcv_pkg::VW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && q_pop)
        begin
            cur_reg <= q_item;
        end
        if (state_reg == S_TOP)
        begin
            top_reg  <= top_c;
            d2_reg   <= d2_c;
            self_reg <= (dx == '0) && (dy == '0);
        end
        if (state_reg == S_SQ)
        begin
            rem_reg <= gcv_pkg::D2W'(t2_c >> gcv_pkg::QN);
            dvd_reg <= t2_c[gcv_pkg::QN-1:0];
            q_reg   <= '0;
            cnt_reg <= CW'(gcv_pkg::QN);
        end
        if (state_reg == S_DIV)
        begin
            rem_reg <= ge ? gcv_pkg::D2W'(sh - {1'b0, d2_reg}) : gcv_pkg::D2W'(sh);
            dvd_reg <= {dvd_reg[gcv_pkg::QN-2:0], 1'b0};
            q_reg   <= {q_reg[gcv_pkg::QN-2:0], ge};
            cnt_reg <= cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            k_reg         <= '0;
            j_reg         <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    addr_reg <= addr_reg + AW'(1);
                    if (addr_reg == AW'(CELLS - 1))
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (q_pop)
                    begin
                        if (q_item.read && q_item.in_map)
                        begin
                            state_reg <= S_RD_WAIT;
                        end
                        else if (q_item.read)
                        begin
                            out_reg       <= '0;
                            out_valid_reg <= 1'b1;
                        end
                        else
                        begin
                            addr_reg  <= '0;
                            k_reg     <= '0;
                            j_reg     <= '0;
                            state_reg <= S_TOP;
                        end
                    end
                end
                S_RD_WAIT:
                begin
                    out_reg       <= rd_data;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                S_TOP:
                begin
                    state_reg <= S_SQ;
                end
                S_SQ:
                begin
                    if (self_reg || (top_reg <= 0))
                    begin
                        addr_reg <= addr_reg + AW'(1);
                        if (k_reg == KW'(MAP_WIDTH - 1))
                        begin
                            k_reg <= '0;
                            j_reg <= j_reg + JW'(1);
                        end
                        else
                        begin
                            k_reg <= k_reg + KW'(1);
                        end
                        state_reg <= last ? S_IDLE : S_TOP;
                    end
                    else
                    begin
                        state_reg <= S_DIV;
                    end
                end
                S_DIV:
                begin
                    if (cnt_reg == CW'(1))
                    begin
                        state_reg <= S_ACC;
                    end
                end
                S_ACC:
                begin
                    addr_reg <= addr_reg + AW'(1);
                    if (k_reg == KW'(MAP_WIDTH - 1))
                    begin
                        k_reg <= '0;
                        j_reg <= j_reg + JW'(1);
                    end
                    else
                    begin
                        k_reg <= k_reg + KW'(1);
                    end
                    state_reg <= last ? S_IDLE : S_TOP;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign out_valid  = out_valid_reg;
    assign vote_value = out_reg;
endmodule
`default_nettype wire

@@ src/gradient_center_vote_map_unit.sv @@
// Top level of the gradient centre vote map.
// With the back end idle, an in-map read is popped in S_IDLE and answered from S_RD_WAIT.
// A vote walks all MAP_WIDTH*MAP_HEIGHT cells: each passes S_TOP and S_SQ, and a cell that
// gets a vote also passes the 33-step serial divider and S_ACC; other votes are no-ops.
// After reset the map is cleared cell by cell before any queued transaction is carried
// out; a two-entry queue accepts transactions meanwhile.
`default_nettype none
module gradient_center_vote_map_unit #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          command,
    input  wire logic [gcv_pkg::POSW-1:0]      pos_x,
    input  wire logic [gcv_pkg::POSW-1:0]      pos_y,
    input  wire logic signed [gcv_pkg::GW-1:0] grad_x,
    input  wire logic signed [gcv_pkg::GW-1:0] grad_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [gcv_pkg::VW-1:0]             vote_value
);
    logic           q_valid, q_pop;
    gcv_pkg::item_t q_item;

    gcv_front #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .valid   (in_valid),
        .ready   (in_ready),
        .command (command),
        .pos_x   (pos_x),
        .pos_y   (pos_y),
        .grad_x  (grad_x),
        .grad_y  (grad_y),
        .q_valid (q_valid),
        .q_item  (q_item),
        .q_pop   (q_pop)
    );

    gcv_back #(.MAP_WIDTH(MAP_WIDTH), .MAP_HEIGHT(MAP_HEIGHT)) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .vote_value (vote_value)
    );
endmodule
`default_nettype wire

@@ test/gcv_checker.sv @@
// Checker for the vote map: predicts the map and compares every returned entry.
`timescale 1ns / 1ps
module gcv_checker #(
    parameter int MAP_WIDTH  = 64,
    parameter int MAP_HEIGHT = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    input  wire logic                          in_ready,
    input  wire logic                          command,
    input  wire logic [gcv_pkg::POSW-1:0]      pos_x,
    input  wire logic [gcv_pkg::POSW-1:0]      pos_y,
    input  wire logic signed [gcv_pkg::GW-1:0] grad_x,
    input  wire logic signed [gcv_pkg::GW-1:0] grad_y,
    input  wire logic                          out_valid,
    input  wire logic                          out_ready,
    input  wire logic [gcv_pkg::VW-1:0]        vote_value,
    output int                                 error_count,
    output int                                 pending_reads,
    output int                                 vote_count,
    output int                                 read_count
);
    localparam logic [gcv_pkg::VW-1:0] VOTE_CEIL = {gcv_pkg::VW{1'b1}};

    logic [gcv_pkg::VW-1:0] map_model [MAP_WIDTH*MAP_HEIGHT];
    logic [gcv_pkg::VW-1:0] expected_entries [$];

    // Adds the squared cosine-weighted vote of one gradient pixel, with saturation, to every candidate with top > 0.
    task automatic apply_vote(input int px, input int py, input longint gx, input longint gy);
        longint dx;
        longint dy;
        longint top;
        longint unsigned t2;
        longint unsigned d2;
        longint unsigned term;
        int idx;
        for (int j = 0; j < MAP_HEIGHT; j++)
        begin
            for (int k = 0; k < MAP_WIDTH; k++)
            begin
                dx = px - k;
                dy = py - j;
                if (dx == 0 && dy == 0)
                    continue;
                top = gx * dx + gy * dy;
                if (top <= 0)
                    continue;
                t2 = top * top;
                d2 = dx * dx + dy * dy;
                term = t2 / d2;
                idx = j * MAP_WIDTH + k;
                if (map_model[idx] > VOTE_CEIL - term)
                    map_model[idx] = VOTE_CEIL;
                else
                    map_model[idx] = map_model[idx] + term;
            end
        end
    endtask

    initial
    begin
        error_count = 0;
        pending_reads = 0;
        vote_count = 0;
        read_count = 0;
        for (int i = 0; i < MAP_WIDTH*MAP_HEIGHT; i++)
            map_model[i] = '0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_entries.size() == 0)
                begin
                    $error("vote_value: unexpected transaction, actual %0d", vote_value);
                    error_count++;
                end
                else
                begin
                    if (vote_value !== expected_entries[0])
                    begin
                        $error("vote_value: expected %0d, actual %0d",
                               expected_entries[0], vote_value);
                        error_count++;
                    end
                    void'(expected_entries.pop_front());
                end
            end
            if (in_valid && in_ready)
            begin
                if (command)
                begin
                    read_count++;
                    if (pos_x < MAP_WIDTH && pos_y < MAP_HEIGHT)
                        expected_entries.push_back(map_model[pos_y*MAP_WIDTH + pos_x]);
                    else
                        expected_entries.push_back('0);
                end
                else
                begin
                    vote_count++;
                    if (pos_x < MAP_WIDTH && pos_y < MAP_HEIGHT &&
                        !(grad_x == 0 && grad_y == 0))
                        apply_vote(pos_x, pos_y, grad_x, grad_y);
                end
            end
            pending_reads = expected_entries.size();
        end
    end
endmodule

@@ test/tb_gradient_center_vote_map_unit.sv @@
// Testbench top for the gradient centre vote map: stimulus, watchdog and verdict.
`timescale 1ns / 1ps
module tb_gradient_center_vote_map_unit;
    localparam int STALL_LIMIT = 1000000;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_ready;
    logic                          command;
    logic [gcv_pkg::POSW-1:0]      pos_x;
    logic [gcv_pkg::POSW-1:0]      pos_y;
    logic signed [gcv_pkg::GW-1:0] grad_x;
    logic signed [gcv_pkg::GW-1:0] grad_y;
    logic                          out_valid;
    logic                          out_ready;
    logic [gcv_pkg::VW-1:0]        vote_value;
    int                            error_count;
    int                            pending_reads;
    int                            vote_count;
    int                            read_count;
    logic                          calm;
    int                            quiet_cycles;

    gradient_center_vote_map_unit u_top (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .pos_x(pos_x), .pos_y(pos_y), .grad_x(grad_x),
        .grad_y(grad_y), .out_valid(out_valid), .out_ready(out_ready),
        .vote_value(vote_value)
    );

    gcv_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .pos_x(pos_x), .pos_y(pos_y), .grad_x(grad_x),
        .grad_y(grad_y), .out_valid(out_valid), .out_ready(out_ready),
        .vote_value(vote_value), .error_count(error_count),
        .pending_reads(pending_reads), .vote_count(vote_count), .read_count(read_count)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= calm || ($urandom_range(99) >= 33);
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic send_transaction(input logic cmd, input logic [gcv_pkg::POSW-1:0] x,
                                    input logic [gcv_pkg::POSW-1:0] y,
                                    input logic signed [gcv_pkg::GW-1:0] gx,
                                    input logic signed [gcv_pkg::GW-1:0] gy);
        while (!calm && $urandom_range(99) < 33)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        command <= cmd;
        pos_x <= x;
        pos_y <= y;
        grad_x <= gx;
        grad_y <= gy;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic read_entry(input logic [gcv_pkg::POSW-1:0] x,
                              input logic [gcv_pkg::POSW-1:0] y);
        send_transaction(1'b1, x, y, gcv_pkg::GW'($urandom), gcv_pkg::GW'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        command = 1'b0;
        pos_x = '0;
        pos_y = '0;
        grad_x = '0;
        grad_y = '0;
        out_ready = 1'b0;
        calm = 1'b0;
        quiet_cycles = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        read_entry(0, 0);
        read_entry(63, 63);
        send_transaction(1'b0, 0, 0, 16'sh7fff, 16'sh7fff);
        read_entry(0, 0);
        read_entry(63, 63);
        read_entry(0, 63);
        send_transaction(1'b0, 63, 63, -16'sh8000, -16'sh8000);
        read_entry(0, 0);
        read_entry(62, 62);
        send_transaction(1'b0, 20, 40, 16'sh0000, 16'sh0000);
        read_entry(20, 40);
        send_transaction(1'b0, 31, 17, -16'sh8000, 16'sh7fff);
        read_entry(31, 17);
        read_entry(30, 17);
        read_entry(63, 0);
        read_entry(32, 18);

        for (int i = 0; i < 122; i++)
        begin
            calm = (i >= 40 && i < 70);
            if (i == 90)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
                while (pending_reads != 0)
                    @(posedge clk);
            end
            if ($urandom_range(99) < 5)
                send_transaction(1'b0, gcv_pkg::POSW'($urandom), gcv_pkg::POSW'($urandom),
                                 gcv_pkg::GW'($urandom), gcv_pkg::GW'($urandom));
            else
                read_entry(gcv_pkg::POSW'($urandom), gcv_pkg::POSW'($urandom));
        end
        send_transaction(1'b0, gcv_pkg::POSW'($urandom), gcv_pkg::POSW'($urandom),
                         gcv_pkg::GW'($urandom), gcv_pkg::GW'($urandom));
        read_entry(gcv_pkg::POSW'($urandom), gcv_pkg::POSW'($urandom));
        in_valid <= 1'b0;
        calm = 1'b0;

        @(posedge clk);
        while (pending_reads != 0)
            @(posedge clk);
        repeat (50) @(posedge clk);

        $display("Covered %0d vote and %0d read transactions, including extreme gradients,",
                 vote_count, read_count);
        $display("a zero gradient, corner pixels and pauses on both channels.");
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
